@@ rtl/hpt_pkg.sv @@
// Shared types and constants for the homogeneous point transform.
`default_nettype none

package hpt_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 4;
  localparam int EPS_W  = 31;
  localparam int DIM    = 4;
  localparam int N_ENTRY = DIM * DIM;
  localparam int LANES  = 3;
  localparam int PROD_W = 2 * DATA_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_POINT  = 2'd1,
    KIND_VECTOR = 2'd2,
    KIND_RSVD   = 2'd3
  } kind_t;

  typedef logic signed [DATA_W-1:0] fix_t;

  typedef struct packed {
    kind_t             kind;
    logic [IDX_W-1:0]  entry_index;
    fix_t              entry_value;
    fix_t              x;
    fix_t              y;
    fix_t              z;
    fix_t              w;
  } in_item_t;

  typedef struct packed {
    logic               valid;
    logic               is_point;
    fix_t [DIM-1:0]     r;
    logic               sat;
  } rows_t;

  typedef struct packed {
    logic                          valid;
    logic                          do_div;
    logic [DATA_W-1:0]             absw;
    logic [LANES-1:0]              neg;
    logic [LANES-1:0][DATA_W-1:0]  absc;
    fix_t [DIM-1:0]                r;
    logic                          sat;
  } div_setup_t;

  typedef struct packed {
    logic                          valid;
    logic                          do_div;
    logic [DATA_W-1:0]             absw;
    logic [LANES-1:0]              neg;
    logic [LANES-1:0]              ovf;
    logic [LANES-1:0][DATA_W-1:0]  rem;
    logic [LANES-1:0][DATA_W-1:0]  lo;
    logic [LANES-1:0][DATA_W-1:0]  q;
    fix_t [DIM-1:0]                r;
    logic                          sat;
  } div_st_t;

  typedef struct packed {
    fix_t x;
    fix_t y;
    fix_t z;
    fix_t w;
    logic divided;
    logic saturated;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/hpt_ifs.sv @@
// Channel interfaces: input items, results and the configuration write.
`default_nettype none

interface hpt_in_if import hpt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic [IDX_W-1:0]    entry_index;
  logic signed [DATA_W-1:0] entry_value;
  logic signed [DATA_W-1:0] in_x;
  logic signed [DATA_W-1:0] in_y;
  logic signed [DATA_W-1:0] in_z;
  logic signed [DATA_W-1:0] in_w;

  modport source (output valid, kind, entry_index, entry_value, in_x, in_y, in_z, in_w,
                  input ready);
  modport sink (input valid, kind, entry_index, entry_value, in_x, in_y, in_z, in_w,
                output ready);
endinterface

interface hpt_out_if import hpt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic signed [DATA_W-1:0] out_x;
  logic signed [DATA_W-1:0] out_y;
  logic signed [DATA_W-1:0] out_z;
  logic signed [DATA_W-1:0] out_w;
  logic                divided;
  logic                saturated;

  modport source (output valid, out_x, out_y, out_z, out_w, divided, saturated,
                  input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, divided, saturated,
                output ready);
endinterface

interface hpt_cfg_if import hpt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [EPS_W-1:0] w_epsilon;

  modport source (output valid, w_epsilon, input ready);
  modport sink (input valid, w_epsilon, output ready);
endinterface

`default_nettype wire

@@ rtl/homogeneous_point_transform_top.sv @@
// Top level of the 4x4 homogeneous point transform in signed fixed point.
// Items arrive on in_ch: kind 0 loads one matrix entry, kind 1 transforms the
// point (x,y,z,1) and divides x, y, z by w when |w| reaches w_epsilon and w is
// not zero, kind 2 transforms the vector (x,y,z,w) without division. Kind 3 is
// dropped. Loads and dropped items give no result; each transform gives one
// result on out_ch. cfg_ch writes w_epsilon and is always ready; write it only
// while no transform is in flight.
// From the input transfer to out_ch.valid an item passes four stages of entry,
// products and row sums, two divider setup stages, 32 quotient-bit stages,
// the result register and the two-entry output buffer. One item is taken
// every cycle while the output buffer is not full.
// Reset loads the identity matrix, sets w_epsilon to one LSB and empties the
// pipeline. When the receiver stalls, the output buffer fills; once both
// entries are held the whole pipeline freezes and in_ch.ready drops until a
// result is transferred. Nothing is dropped or repeated.
`default_nettype none

module homogeneous_point_transform_top import hpt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  hpt_in_if.sink         in_ch,
  hpt_out_if.source      out_ch,
  hpt_cfg_if.sink        cfg_ch
);

  logic             en;
  logic [EPS_W-1:0] eps_r;
  in_item_t         item;
  rows_t            rows;
  logic             res_valid;
  result_t          res;
  result_t          dout;

  assign in_ch.ready = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_W'(1);
    end else if (cfg_ch.valid) begin
      eps_r <= cfg_ch.w_epsilon;
    end
  end

  always_comb begin
    item.kind = kind_t'(in_ch.kind);
    item.entry_index = in_ch.entry_index;
    item.entry_value = in_ch.entry_value;
    item.x = in_ch.in_x;
    item.y = in_ch.in_y;
    item.z = in_ch.in_z;
    item.w = in_ch.in_w;
  end

  hpt_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .in_item  (item),
    .rows     (rows)
  );

  hpt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .eps       (eps_r),
    .rows      (rows),
    .res_valid (res_valid),
    .res       (res)
  );

  hpt_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid && en),
    .din       (res),
    .space     (en),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .dout      (dout)
  );

  assign out_ch.out_x = dout.x;
  assign out_ch.out_y = dout.y;
  assign out_ch.out_z = dout.z;
  assign out_ch.out_w = dout.w;
  assign out_ch.divided = dout.divided;
  assign out_ch.saturated = dout.saturated;

endmodule

`default_nettype wire

@@ rtl/hpt_mac.sv @@
// Matrix store, sixteen parallel products and the clamped row sums.
`default_nettype none

module hpt_mac import hpt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_valid,
  input  in_item_t in_item,
  output rows_t    rows
);

  localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

  logic      s0_valid_r;
  in_item_t  s0_item_r;
  fix_t      matrix_r [N_ENTRY];

  logic                     s1_valid_r;
  logic                     s1_point_r;
  logic signed [PROD_W-1:0] prod_r [DIM][DIM];

  logic                     s2_valid_r;
  logic                     s2_point_r;
  logic signed [PAIR_W-1:0] pair_r [DIM][2];

  rows_t rows_r;
  rows_t rows_nxt;

  fix_t vec_c [DIM];
  logic s0_xform_c;

  logic signed [SUM_W-1:0] sum_c [DIM];
  logic signed [SUM_W-1:0] shr_c [DIM];

  assign s0_xform_c = s0_valid_r &&
                      (s0_item_r.kind == KIND_POINT || s0_item_r.kind == KIND_VECTOR);

  always_comb begin
    vec_c[0] = s0_item_r.x;
    vec_c[1] = s0_item_r.y;
    vec_c[2] = s0_item_r.z;
    vec_c[3] = (s0_item_r.kind == KIND_POINT) ? fix_t'(ONE) : s0_item_r.w;
  end

  // A load writes the matrix as it leaves the entry register, so every
  // transform sees exactly the loads that were transferred before it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          matrix_r[r*DIM+c] <= (r == c) ? fix_t'(ONE) : '0;
        end
      end
    end else if (en) begin
      s0_valid_r <= in_valid;
      if (s0_valid_r && s0_item_r.kind == KIND_LOAD) begin
        matrix_r[s0_item_r.entry_index] <= s0_item_r.entry_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      rows_r.valid <= 1'b0;
    end else if (en) begin
      s1_valid_r <= s0_xform_c;
      s2_valid_r <= s1_valid_r;
      rows_r <= rows_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_point_r <= (s0_item_r.kind == KIND_POINT);
      s2_point_r <= s1_point_r;
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          prod_r[r][c] <= $signed(matrix_r[r*DIM+c]) * $signed(vec_c[c]);
        end
        pair_r[r][0] <= PAIR_W'(prod_r[r][0]) + PAIR_W'(prod_r[r][1]);
        pair_r[r][1] <= PAIR_W'(prod_r[r][2]) + PAIR_W'(prod_r[r][3]);
      end
    end
  end

  // Row sum, floor shift by the fraction width, clamp to 32 bits.
  always_comb begin
    rows_nxt = '0;
    rows_nxt.valid = s2_valid_r;
    rows_nxt.is_point = s2_point_r;
    for (int r = 0; r < DIM; r++) begin
      sum_c[r] = SUM_W'(pair_r[r][0]) + SUM_W'(pair_r[r][1]);
      shr_c[r] = sum_c[r] >>> FRAC_BITS;
      if (shr_c[r] > SUM_W'(S_MAX)) begin
        rows_nxt.r[r] = S_MAX;
        rows_nxt.sat = 1'b1;
      end else if (shr_c[r] < SUM_W'(S_MIN)) begin
        rows_nxt.r[r] = S_MIN;
        rows_nxt.sat = 1'b1;
      end else begin
        rows_nxt.r[r] = shr_c[r][DATA_W-1:0];
      end
    end
  end

  assign rows = rows_r;

endmodule

`default_nettype wire

@@ rtl/hpt_div.sv @@
// Perspective divide: three pipelined restoring dividers, one quotient bit per stage.
`default_nettype none

module hpt_div import hpt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [EPS_W-1:0] eps,
  input  rows_t            rows,
  output logic             res_valid,
  output result_t          res
);

  div_setup_t setup_r;
  div_setup_t setup_nxt;
  div_st_t    st_r [DATA_W+1];
  div_st_t    init_nxt;
  logic       res_valid_r;
  result_t    res_r;
  result_t    res_nxt;

  logic [DATA_W-1:0] absw_c;
  fix_t              qval_c [LANES];
  logic [LANES-1:0]  qsat_c;

  always_comb begin
    setup_nxt = '0;
    absw_c = rows.r[3][DATA_W-1] ? (~rows.r[3] + 1'b1) : rows.r[3];
    setup_nxt.valid = rows.valid;
    setup_nxt.absw = absw_c;
    setup_nxt.do_div = rows.is_point && (rows.r[3] != '0) &&
                       (absw_c >= {1'b0, eps});
    setup_nxt.r = rows.r;
    setup_nxt.sat = rows.sat;
    for (int l = 0; l < LANES; l++) begin
      setup_nxt.absc[l] = rows.r[l][DATA_W-1] ? (~rows.r[l] + 1'b1) : rows.r[l];
      setup_nxt.neg[l] = rows.r[l][DATA_W-1] ^ rows.r[3][DATA_W-1];
    end
  end

  // The numerator is |c| shifted up by the fraction width. Its bits above
  // 32 seed the remainder; if they already reach |w| the quotient needs
  // more than 32 bits and the lane saturates.
  always_comb begin
    init_nxt = '0;
    init_nxt.valid = setup_r.valid;
    init_nxt.do_div = setup_r.do_div;
    init_nxt.absw = setup_r.absw;
    init_nxt.neg = setup_r.neg;
    init_nxt.r = setup_r.r;
    init_nxt.sat = setup_r.sat;
    for (int l = 0; l < LANES; l++) begin
      init_nxt.rem[l] = DATA_W'(setup_r.absc[l][DATA_W-1 -: FRAC_BITS]);
      init_nxt.ovf[l] = DATA_W'(setup_r.absc[l][DATA_W-1 -: FRAC_BITS]) >= setup_r.absw;
      init_nxt.lo[l] = setup_r.absc[l] << FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_r.valid <= 1'b0;
      st_r[0].valid <= 1'b0;
    end else if (en) begin
      setup_r <= setup_nxt;
      st_r[0] <= init_nxt;
    end
  end

  for (genvar k = 1; k <= DATA_W; k++) begin : g_iter
    div_st_t          st_nxt;
    logic [DATA_W:0]  sh_c [LANES];

    always_comb begin
      st_nxt = st_r[k-1];
      for (int l = 0; l < LANES; l++) begin
        sh_c[l] = {st_r[k-1].rem[l], st_r[k-1].lo[l][DATA_W-1]};
        if (sh_c[l] >= {1'b0, st_r[k-1].absw}) begin
          st_nxt.rem[l] = DATA_W'(sh_c[l] - {1'b0, st_r[k-1].absw});
          st_nxt.q[l] = {st_r[k-1].q[l][DATA_W-2:0], 1'b1};
        end else begin
          st_nxt.rem[l] = sh_c[l][DATA_W-1:0];
          st_nxt.q[l] = {st_r[k-1].q[l][DATA_W-2:0], 1'b0};
        end
        st_nxt.lo[l] = st_r[k-1].lo[l] << 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[k].valid <= 1'b0;
      end else if (en) begin
        st_r[k] <= st_nxt;
      end
    end
  end

  // Apply the sign to the quotient magnitude and clamp; undivided items pass the row values.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      qsat_c[l] = 1'b0;
      if (st_r[DATA_W].ovf[l]) begin
        qsat_c[l] = 1'b1;
        qval_c[l] = st_r[DATA_W].neg[l] ? S_MIN : S_MAX;
      end else if (st_r[DATA_W].neg[l]) begin
        if (st_r[DATA_W].q[l] > DATA_W'(S_MIN)) begin
          qsat_c[l] = 1'b1;
          qval_c[l] = S_MIN;
        end else begin
          qval_c[l] = ~st_r[DATA_W].q[l] + 1'b1;
        end
      end else if (st_r[DATA_W].q[l][DATA_W-1]) begin
        qsat_c[l] = 1'b1;
        qval_c[l] = S_MAX;
      end else begin
        qval_c[l] = st_r[DATA_W].q[l];
      end
    end

    res_nxt.w = st_r[DATA_W].r[3];
    res_nxt.divided = st_r[DATA_W].do_div;
    if (st_r[DATA_W].do_div) begin
      res_nxt.x = qval_c[0];
      res_nxt.y = qval_c[1];
      res_nxt.z = qval_c[2];
      res_nxt.saturated = st_r[DATA_W].sat | (|qsat_c);
    end else begin
      res_nxt.x = st_r[DATA_W].r[0];
      res_nxt.y = st_r[DATA_W].r[1];
      res_nxt.z = st_r[DATA_W].r[2];
      res_nxt.saturated = st_r[DATA_W].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (en) begin
      res_valid_r <= st_r[DATA_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res = res_r;

endmodule

`default_nettype wire

@@ rtl/hpt_obuf.sv @@
// Two-entry result buffer that decouples the pipeline from the receiver.
`default_nettype none

module hpt_obuf import hpt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t din,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t dout
);

  result_t    buf_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       pop;

  assign pop = (count_r != 2'd0) && out_ready;
  assign space = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign dout = buf_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

@@ rtl/hpt_checker.sv @@
// Port-level assertions for the point transform, bound to the top level.
`default_nettype none

module hpt_checker import hpt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic signed [DATA_W-1:0] out_x,
  input logic signed [DATA_W-1:0] out_w,
  input logic        divided
);

  // A held result keeps its x, w and divided values until it is transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_w) &&
                                $stable(divided))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // The output buffer never stays full across a cycle in which the receiver took data.
  a_ready_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(out_ready) |-> in_ready)
    else $error("input stalled although the receiver was ready");

  a_div_nonzero_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && divided |-> out_w != '0)
    else $error("division reported with zero w");

endmodule

bind homogeneous_point_transform_top hpt_checker u_hpt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_x     (out_ch.out_x),
  .out_w     (out_ch.out_w),
  .divided   (out_ch.divided)
);

`default_nettype wire
